[design/hfmn_pkg.sv]
// hfmn_pkg: field widths, codes and the command type shared by the fork mutex node
// no dependencies; imported by every module of the node

package hfmn_pkg;

  localparam int KIND_W     = 3;
  localparam int PEER_W     = 4;
  localparam int MSG_W      = 2;
  localparam int SELF_W     = 4;
  localparam int CNT_W      = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam int Q_DEPTH    = 2;

  // input kinds
  localparam logic [KIND_W-1:0] KIND_INIT    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REQUEST = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REPLY   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_POLL    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_FINISH  = 3'd5;

  // result message kinds
  localparam logic [MSG_W-1:0] MSG_STATUS  = 2'd0;
  localparam logic [MSG_W-1:0] MSG_REQUEST = 2'd1;
  localparam logic [MSG_W-1:0] MSG_REPLY   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SELF_ID    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'b1;

  typedef enum logic [2:0] {
    OP_INIT,
    OP_REQ,
    OP_REP,
    OP_REL,
    OP_POLL,
    OP_FIN,
    OP_NOP,
    OP_BAD
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [PEER_W-1:0] peer;
  } cmd_t;

endpackage

[design/hfmn_front.sv]
// hfmn_front: accepts input transfers and classifies them into commands
// depends on hfmn_pkg

module hfmn_front #(
  parameter int NW = 7
) (
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [hfmn_pkg::KIND_W-1:0]   in_kind,
  input  logic [hfmn_pkg::PEER_W-1:0]   in_peer_id,
  input  logic [hfmn_pkg::SELF_W-1:0]   self_eff,
  input  logic [NW-1:0]                 count_eff,
  input  logic                          q_full,
  output logic                          q_push,
  output hfmn_pkg::cmd_t                q_cmd
);
  import hfmn_pkg::*;

  logic [NW-1:0] peer_w;
  logic          is_peer;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  assign peer_w  = NW'(in_peer_id);
  assign is_peer = (peer_w != '0) && (peer_w < count_eff) && (in_peer_id != self_eff);

  always_comb begin
    q_cmd.peer = in_peer_id;
    case (in_kind)
      KIND_INIT:    q_cmd.op = OP_INIT;
      KIND_REQUEST: q_cmd.op = is_peer ? OP_REQ : OP_BAD;
      KIND_REPLY:   q_cmd.op = is_peer ? OP_REP : OP_BAD;
      KIND_RELEASE: q_cmd.op = OP_REL;
      KIND_POLL:    q_cmd.op = OP_POLL;
      KIND_FINISH:  q_cmd.op = OP_FIN;
      default:      q_cmd.op = OP_NOP;
    endcase
  end

endmodule

[design/hfmn_cmd_fifo.sv]
// hfmn_cmd_fifo: two-entry command queue between front and back
// depends on hfmn_pkg

module hfmn_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  hfmn_pkg::cmd_t push_cmd,
  input  logic           pop,
  output hfmn_pkg::cmd_t pop_cmd,
  output logic           full,
  output logic           empty
);
  import hfmn_pkg::*;

  localparam int PW = $clog2(Q_DEPTH);
  localparam int CW = $clog2(Q_DEPTH + 1);

  cmd_t          q_r [Q_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == CW'(Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_cmd = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : PW'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : PW'(rd_ptr_r + 1'b1);
    end
    if (push && !pop) begin
      cnt_nxt = CW'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = CW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[design/hfmn_back.sv]
// hfmn_back: holds the per-peer fork marks, runs commands and poll sweeps,
// and drives the result register; depends on hfmn_pkg

module hfmn_back #(
  parameter int MAX_NODES = 16,
  parameter int NW        = 7
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [hfmn_pkg::SELF_W-1:0]  self_eff,
  input  logic [NW-1:0]                count_eff,
  input  logic                         q_empty,
  input  hfmn_pkg::cmd_t               q_cmd,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [hfmn_pkg::MSG_W-1:0]   out_msg_kind,
  output logic [hfmn_pkg::PEER_W-1:0]  out_dest_node,
  output logic                         out_may_enter,
  output logic                         out_bad_peer,
  output logic                         out_last
);
  import hfmn_pkg::*;

  localparam int IW = $clog2(MAX_NODES);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_SWEEP = 2'b10
  } state_t;

  state_t                 state_r, state_nxt;
  logic [NW-1:0]          cnt_r, cnt_nxt;
  logic [MAX_NODES-1:0]   holds_r, holds_nxt;
  logic [MAX_NODES-1:0]   dirty_r, dirty_nxt;
  logic [MAX_NODES-1:0]   asked_r, asked_nxt;
  logic [MAX_NODES-1:0]   sasked_r, sasked_nxt;
  logic                   fin_r, fin_nxt;

  logic [MAX_NODES-1:0]   peer_mask, hi_mask, lo_mask;
  logic [NW-1:0]          self_w, peer_w;
  logic [IW-1:0]          pidx, cur;
  logic                   in_range, is_self, hb, rq, out_free;

  logic                   emit;
  logic [MSG_W-1:0]       e_kind;
  logic [PEER_W-1:0]      e_dest;
  logic                   e_bad, e_last, may_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [MSG_W-1:0]       out_kind_r;
  logic [PEER_W-1:0]      out_dest_r;
  logic                   out_may_r, out_bad_r, out_last_r;

  assign self_w = NW'(self_eff);
  assign peer_w = NW'(q_cmd.peer);
  assign pidx   = peer_w[IW-1:0];
  assign cur    = cnt_r[IW-1:0];

  // peer classes for the whole-table commands
  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      peer_mask[i] = (i != 0) && (NW'(i) < count_eff) && (NW'(i) != self_w);
      hi_mask[i]   = (NW'(i) > self_w) && (NW'(i) < count_eff);
      lo_mask[i]   = (i != 0) && (NW'(i) < self_w) && (NW'(i) < count_eff);
    end
  end

  assign out_free = !out_valid_r || out_ready;
  assign in_range = cnt_r < count_eff;
  assign is_self  = cnt_r == self_w;
  assign hb       = asked_r[cur] && holds_r[cur] && (dirty_r[cur] || fin_r);
  assign rq       = !fin_r && !holds_r[cur] && !sasked_r[cur];

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    holds_nxt  = holds_r;
    dirty_nxt  = dirty_r;
    asked_nxt  = asked_r;
    sasked_nxt = sasked_r;
    fin_nxt    = fin_r;
    q_pop      = 1'b0;
    emit       = 1'b0;
    e_kind     = MSG_STATUS;
    e_dest     = '0;
    e_bad      = 1'b0;
    e_last     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          if (q_cmd.op == OP_POLL) begin
            q_pop     = 1'b1;
            cnt_nxt   = NW'(1);
            state_nxt = ST_SWEEP;
          end else if (out_free) begin
            q_pop  = 1'b1;
            emit   = 1'b1;
            e_last = 1'b1;
            case (q_cmd.op)
              OP_INIT: begin
                holds_nxt  = hi_mask;
                dirty_nxt  = hi_mask;
                asked_nxt  = lo_mask;
                sasked_nxt = '0;
                fin_nxt    = 1'b0;
              end
              OP_REQ: asked_nxt[pidx] = 1'b1;
              OP_REP: begin
                holds_nxt[pidx]  = 1'b1;
                dirty_nxt[pidx]  = 1'b0;
                sasked_nxt[pidx] = 1'b0;
              end
              OP_REL: dirty_nxt = dirty_r | peer_mask;
              OP_FIN: fin_nxt = 1'b1;
              OP_BAD: e_bad = 1'b1;
              default: ;
            endcase
          end
        end
      end
      ST_SWEEP: begin
        if (!in_range) begin
          if (out_free) begin
            emit      = 1'b1;
            e_last    = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else if (is_self) begin
          cnt_nxt = NW'(cnt_r + 1'b1);
        end else if (hb) begin
          // hand the fork back; the same peer is looked at again next cycle
          if (out_free) begin
            emit           = 1'b1;
            e_kind         = MSG_REPLY;
            e_dest         = cnt_r[PEER_W-1:0];
            holds_nxt[cur] = 1'b0;
            dirty_nxt[cur] = 1'b0;
            asked_nxt[cur] = 1'b0;
          end
        end else if (rq) begin
          if (out_free) begin
            emit            = 1'b1;
            e_kind          = MSG_REQUEST;
            e_dest          = cnt_r[PEER_W-1:0];
            sasked_nxt[cur] = 1'b1;
            cnt_nxt         = NW'(cnt_r + 1'b1);
          end
        end else begin
          cnt_nxt = NW'(cnt_r + 1'b1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // entry rule on the marks as they stand after this result
  assign may_nxt = &(~peer_mask | (holds_nxt & (~dirty_nxt | ~asked_nxt)));

  assign out_valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      holds_r     <= '0;
      dirty_r     <= '0;
      asked_r     <= '0;
      sasked_r    <= '0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      holds_r     <= holds_nxt;
      dirty_r     <= dirty_nxt;
      asked_r     <= asked_nxt;
      sasked_r    <= sasked_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r <= e_kind;
      out_dest_r <= e_dest;
      out_may_r  <= may_nxt;
      out_bad_r  <= e_bad;
      out_last_r <= e_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_msg_kind  = out_kind_r;
  assign out_dest_node = out_dest_r;
  assign out_may_enter = out_may_r;
  assign out_bad_peer  = out_bad_r;
  assign out_last      = out_last_r;

endmodule

[design/hygienic_fork_mutex_node.sv]
// an item goes through the command queue and then the result register to its first result
// throughput: one non-poll item per cycle while the result register is free; a poll holds the
// back end for its whole sweep, which looks at peers one at a time from 1 upward and looks at
// a peer again after handing its fork back; a full result register stalls the sweep
// reset: synchronous active-low; all fork marks and finished clear, self_id 1, node_count 2
// depends on hfmn_pkg, hfmn_front, hfmn_cmd_fifo, hfmn_back

module hygienic_fork_mutex_node #(
  parameter int MAX_NODES = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [hfmn_pkg::KIND_W-1:0]      in_kind,
  input  logic [hfmn_pkg::PEER_W-1:0]      in_peer_id,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [hfmn_pkg::MSG_W-1:0]       out_msg_kind,
  output logic [hfmn_pkg::PEER_W-1:0]      out_dest_node,
  output logic                             out_may_enter,
  output logic                             out_bad_peer,
  output logic                             out_last,
  input  logic                             cfg_we,
  input  logic [hfmn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hfmn_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import hfmn_pkg::*;

  localparam int NW = (CNT_W > $clog2(MAX_NODES + 1)) ? CNT_W : $clog2(MAX_NODES + 1);

  logic [SELF_W-1:0] self_eff_r;
  logic [NW-1:0]     count_eff_r;
  logic [SELF_W-1:0] self_wr;
  logic [NW-1:0]     count_wr;

  logic q_push, q_pop, q_full, q_empty;
  cmd_t push_cmd, pop_cmd;

  // registers hold the effective values: self 0 reads as 1, count is capped
  assign self_wr  = cfg_wdata[SELF_W-1:0];
  assign count_wr = NW'(cfg_wdata[CNT_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      self_eff_r  <= SELF_W'(1);
      count_eff_r <= NW'(2);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SELF_ID:    self_eff_r  <= (self_wr == '0) ? SELF_W'(1) : self_wr;
        CFG_NODE_COUNT: count_eff_r <= (count_wr > NW'(MAX_NODES)) ? NW'(MAX_NODES)
                                                                   : count_wr;
        default: ;
      endcase
    end
  end

  hfmn_front #(
    .NW(NW)
  ) u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_kind    (in_kind),
    .in_peer_id (in_peer_id),
    .self_eff   (self_eff_r),
    .count_eff  (count_eff_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (push_cmd)
  );

  hfmn_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  hfmn_back #(
    .MAX_NODES(MAX_NODES),
    .NW       (NW)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .self_eff      (self_eff_r),
    .count_eff     (count_eff_r),
    .q_empty       (q_empty),
    .q_cmd         (pop_cmd),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_msg_kind  (out_msg_kind),
    .out_dest_node (out_dest_node),
    .out_may_enter (out_may_enter),
    .out_bad_peer  (out_bad_peer),
    .out_last      (out_last)
  );

endmodule

[design/hfmn_checker.sv]
// hfmn_props: port-level assertions for the fork mutex node, bound to the top level
// depends on hfmn_pkg

module hfmn_props (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [hfmn_pkg::MSG_W-1:0]       out_msg_kind,
  input logic [hfmn_pkg::PEER_W-1:0]      out_dest_node,
  input logic                             out_may_enter,
  input logic                             out_bad_peer,
  input logic                             out_last
);
  import hfmn_pkg::*;

  // a status result never names a peer
  a_status_no_dest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_msg_kind == MSG_STATUS) |-> (out_dest_node == '0))
    else $error("status result with a destination");

  // messages are only ever followed by more results of the same sweep
  a_msg_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_msg_kind != MSG_STATUS) |-> !out_last && !out_bad_peer)
    else $error("fork message marked last or bad");

  // a rejected peer gives a single closing status
  a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_peer |-> out_last && (out_msg_kind == MSG_STATUS))
    else $error("bad peer result not a final status");

  a_msg_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_msg_kind == MSG_STATUS) || (out_msg_kind == MSG_REQUEST)
                  || (out_msg_kind == MSG_REPLY))
    else $error("undefined message kind");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_msg_kind)
      && $stable(out_dest_node) && $stable(out_may_enter) && $stable(out_bad_peer)
      && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind hygienic_fork_mutex_node hfmn_props u_hfmn_props (.*);

[tb/hfmn_checker.sv]
`timescale 1ns / 100ps
// hfmn_checker: keeps its own copy of the per-peer fork marks and registers, works out
// every result of each input transfer and compares the result channel against it
// depends on hfmn_pkg; instantiated beside the node by hygienic_fork_mutex_node_tb

module hfmn_checker #(
  parameter int MAX_NODES = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [hfmn_pkg::KIND_W-1:0]     in_kind,
  input  logic [hfmn_pkg::PEER_W-1:0]     in_peer_id,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [hfmn_pkg::MSG_W-1:0]      out_msg_kind,
  input  logic [hfmn_pkg::PEER_W-1:0]     out_dest_node,
  input  logic                            out_may_enter,
  input  logic                            out_bad_peer,
  input  logic                            out_last,
  input  logic                            cfg_we,
  input  logic [hfmn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hfmn_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              fail_count,
  output int                              pending_count,
  output int                              result_count
);
  import hfmn_pkg::*;

  typedef struct packed {
    logic [MSG_W-1:0]  msg;
    logic [PEER_W-1:0] dest;
    logic              may_enter;
    logic              bad_peer;
    logic              last;
  } fork_msg_t;

  fork_msg_t              expected_msgs[$];
  logic [MAX_NODES-1:0]   holds, dirty, peer_req, self_req;
  logic                   finished;
  logic [SELF_W-1:0]      self_reg;
  logic [CNT_W-1:0]       count_reg;
  int                     fails = 0;
  int                     seen = 0;

  function automatic int node_limit();
    return (count_reg > MAX_NODES) ? MAX_NODES : int'(count_reg);
  endfunction

  function automatic int self_eff();
    return (self_reg == '0) ? 1 : int'(self_reg);
  endfunction

  // every peer fork held, and clean or not asked for
  function automatic logic enter_ok();
    int n;
    int s;
    n = node_limit();
    s = self_eff();
    for (int i = 1; i < n; i++) begin
      if (i != s && !(holds[i] && (!dirty[i] || !peer_req[i]))) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic push_msg(input logic [MSG_W-1:0] m, input int dest, input logic bad,
                          input logic last);
    fork_msg_t e;
    e.msg       = m;
    e.dest      = dest[PEER_W-1:0];
    e.may_enter = enter_ok();
    e.bad_peer  = bad;
    e.last      = last;
    expected_msgs.push_back(e);
  endtask

  task automatic predict_node(input logic [KIND_W-1:0] kind, input logic [PEER_W-1:0] peer);
    int   n;
    int   s;
    logic bad;
    n   = node_limit();
    s   = self_eff();
    bad = 1'b0;
    case (kind)
      KIND_INIT: begin
        holds    = '0;
        dirty    = '0;
        peer_req = '0;
        self_req = '0;
        finished = 1'b0;
        for (int i = 1; i < n; i++) begin
          if (i > s) begin
            holds[i] = 1'b1;
            dirty[i] = 1'b1;
          end else if (i < s) begin
            peer_req[i] = 1'b1;
          end
        end
      end
      KIND_REQUEST, KIND_REPLY: begin
        if (peer == 0 || peer >= n || peer == s) begin
          bad = 1'b1;
        end else if (kind == KIND_REQUEST) begin
          peer_req[peer] = 1'b1;
        end else begin
          holds[peer]    = 1'b1;
          dirty[peer]    = 1'b0;
          self_req[peer] = 1'b0;
        end
      end
      KIND_RELEASE: begin
        for (int i = 1; i < n; i++) if (i != s) dirty[i] = 1'b1;
      end
      KIND_POLL: begin
        // hand back first, then ask for whatever is missing
        for (int i = 1; i < n; i++) begin
          if (i != s) begin
            if (peer_req[i] && holds[i] && (dirty[i] || finished)) begin
              holds[i]    = 1'b0;
              dirty[i]    = 1'b0;
              peer_req[i] = 1'b0;
              push_msg(MSG_REPLY, i, 1'b0, 1'b0);
            end
            if (!finished && !holds[i] && !self_req[i]) begin
              self_req[i] = 1'b1;
              push_msg(MSG_REQUEST, i, 1'b0, 1'b0);
            end
          end
        end
      end
      KIND_FINISH: finished = 1'b1;
      default: ;
    endcase
    push_msg(MSG_STATUS, 0, bad, 1'b1);
  endtask

  task automatic note_fail(input fork_msg_t e, input fork_msg_t got, input logic orphan);
    fails++;
    if (fails <= 10) begin
      if (orphan)
        $display("mismatch @%0t: result with nothing outstanding (kind %0d dest %0d)",
                 $time, got.msg, got.dest);
      else
        $display({"mismatch @%0t: expected kind %0d dest %0d enter %0b bad %0b last %0b,",
                  " got kind %0d dest %0d enter %0b bad %0b last %0b"},
                 $time, e.msg, e.dest, e.may_enter, e.bad_peer, e.last,
                 got.msg, got.dest, got.may_enter, got.bad_peer, got.last);
    end
  endtask

  always @(posedge clk) begin
    fork_msg_t got;
    fork_msg_t e;
    if (!rst_n) begin
      holds     = '0;
      dirty     = '0;
      peer_req  = '0;
      self_req  = '0;
      finished  = 1'b0;
      self_reg  = 4'd1;
      count_reg = 5'd2;
      expected_msgs.delete();
    end else begin
      // results first, so a stray result never matches a prediction made this edge
      if (out_valid && out_ready) begin
        seen++;
        got = '{out_msg_kind, out_dest_node, out_may_enter, out_bad_peer, out_last};
        if (expected_msgs.size() == 0) begin
          note_fail(got, got, 1'b1);
        end else begin
          e = expected_msgs.pop_front();
          if (got !== e) note_fail(e, got, 1'b0);
        end
      end
      if (in_valid && in_ready) predict_node(in_kind, in_peer_id);
      if (cfg_we) begin
        if (cfg_index == CFG_SELF_ID) self_reg = cfg_wdata[SELF_W-1:0];
        else count_reg = cfg_wdata;
      end
    end
    fail_count    <= fails;
    pending_count <= expected_msgs.size();
    result_count  <= seen;
  end

endmodule

[tb/hygienic_fork_mutex_node_tb.sv]
`timescale 1ns / 100ps
// hygienic_fork_mutex_node_tb: drives directed and random input transfers and register
// settings into the fork mutex node, with random stalls on both sides; hfmn_checker judges
// depends on hfmn_pkg, hfmn_checker and the node itself

module hygienic_fork_mutex_node_tb;
  import hfmn_pkg::*;

  localparam int MAX_NODES      = 16;
  localparam int NUM_PHASES     = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_SETTLE   = 8;
  localparam int HOLD_OFF_LEN   = 200;

  // kinds the node has no use for
  localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

  localparam int PHASE_SELF  [NUM_PHASES] = '{1, 15, 8, 0, 3, 7, 21, 2, 1, 12};
  localparam int PHASE_COUNT [NUM_PHASES] = '{2, 16, 16, 31, 17, 4, 16, 0, 1, 13};
  localparam int PHASE_ITEMS [NUM_PHASES] = '{45, 45, 45, 40, 45, 40, 45, 15, 15, 45};

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_valid   = 1'b0;
  logic                  in_ready;
  logic [KIND_W-1:0]     in_kind    = '0;
  logic [PEER_W-1:0]     in_peer_id = '0;
  logic                  out_valid;
  logic                  out_ready  = 1'b0;
  logic [MSG_W-1:0]      out_msg_kind;
  logic [PEER_W-1:0]     out_dest_node;
  logic                  out_may_enter;
  logic                  out_bad_peer;
  logic                  out_last;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  int   fail_count;
  int   pending;
  int   result_count;
  int   items_sent   = 0;
  int   stuck_cycles = 0;
  int   hold_left    = 0;
  logic hold_done    = 1'b0;
  int   cur_n        = 2;
  int   cur_s        = 1;
  logic no_idle;

  always #6 clk = ~clk;

  hygienic_fork_mutex_node #(.MAX_NODES(MAX_NODES)) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_peer_id    (in_peer_id),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_msg_kind  (out_msg_kind),
    .out_dest_node (out_dest_node),
    .out_may_enter (out_may_enter),
    .out_bad_peer  (out_bad_peer),
    .out_last      (out_last),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  hfmn_checker #(.MAX_NODES(MAX_NODES)) u_fork_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_peer_id    (in_peer_id),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_msg_kind  (out_msg_kind),
    .out_dest_node (out_dest_node),
    .out_may_enter (out_may_enter),
    .out_bad_peer  (out_bad_peer),
    .out_last      (out_last),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending_count (pending),
    .result_count  (result_count)
  );

  // a stretch of the run with no idling on either side
  assign no_idle = (items_sent >= 250) && (items_sent < 330);

  // receiver: random stalls, plus one long hold-off so the node backs up into its input
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && items_sent >= 120) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_OFF_LEN;
      hold_done <= 1'b1;
    end else if (no_idle) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= 25);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("[hygienic_fork_mutex_node] ERROR");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic send_item(input logic [KIND_W-1:0] k, input logic [PEER_W-1:0] p);
    if (!no_idle && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_kind    <= k;
    in_peer_id <= p;
    do @(posedge clk); while (!(in_valid && in_ready));
    items_sent <= items_sent + 1;
  endtask

  // mostly well-formed traffic between valid peers, some stray ids and spare kinds
  task automatic send_random();
    logic [KIND_W-1:0] k;
    logic [PEER_W-1:0] p;
    int                r;
    int                npeers;
    npeers = (cur_n > 1) ? (cur_n - 1 - ((cur_s < cur_n) ? 1 : 0)) : 0;
    p      = PEER_W'($urandom_range(0, 15));
    r      = $urandom_range(0, 99);
    if (r < 4)       k = KIND_INIT;
    else if (r < 30) k = KIND_REQUEST;
    else if (r < 52) k = KIND_REPLY;
    else if (r < 60) k = KIND_RELEASE;
    else if (r < 82) k = KIND_POLL;
    else if (r < 85) k = KIND_FINISH;
    else if (r < 95) k = $urandom_range(0, 1) ? KIND_REQUEST : KIND_REPLY;
    else             k = $urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B;
    if (r >= 4 && r < 52 && npeers > 0) begin
      do p = PEER_W'($urandom_range(1, cur_n - 1)); while (p == cur_s);
    end
    send_item(k, p);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_node(input int self_val, input int count_val);
    write_reg(CFG_SELF_ID, self_val[CFG_DATA_W-1:0]);
    write_reg(CFG_NODE_COUNT, count_val[CFG_DATA_W-1:0]);
    cfg_we <= 1'b0;
    cur_s  = ((self_val & 15) == 0) ? 1 : (self_val & 15);
    cur_n  = (count_val > MAX_NODES) ? MAX_NODES : count_val;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_SETTLE) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: node 5 of eight
    set_node(5, 9);
    send_item(KIND_POLL, 4'd0);
    send_item(KIND_INIT, 4'd15);
    send_item(KIND_POLL, 4'd0);
    send_item(KIND_REQUEST, 4'd6);
    send_item(KIND_REPLY, 4'd1);
    send_item(KIND_REPLY, 4'd2);
    send_item(KIND_REPLY, 4'd3);
    send_item(KIND_REPLY, 4'd4);
    send_item(KIND_POLL, 4'd3);
    send_item(KIND_REPLY, 4'd6);
    send_item(KIND_REQUEST, 4'd0);
    send_item(KIND_REQUEST, 4'd5);
    send_item(KIND_REQUEST, 4'd9);
    send_item(KIND_REPLY, 4'd15);
    send_item(KIND_REPLY, 4'd0);
    send_item(KIND_RELEASE, 4'd8);
    send_item(KIND_REQUEST, 4'd7);
    send_item(KIND_POLL, 4'd12);
    send_item(KIND_FINISH, 4'd0);
    send_item(KIND_REQUEST, 4'd1);
    send_item(KIND_POLL, 4'd0);
    send_item(KIND_SPARE_A, 4'd15);
    send_item(KIND_SPARE_B, 4'd0);
    send_item(KIND_INIT, 4'd7);
    send_item(KIND_POLL, 4'd0);
    wait_drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_node(PHASE_SELF[ph], PHASE_COUNT[ph]);
      for (int j = 0; j < PHASE_ITEMS[ph]; j++) begin
        // sender holds back until the node has emptied
        if (ph == 2 && j == 20) wait_drain();
        send_random();
      end
      wait_drain();
    end

    $display("%0d input transfers over %0d register settings, %0d results checked",
             items_sent, NUM_PHASES + 1, result_count);
    $display("all kinds incl. spare codes, ids 0 to 15, extreme self ids and node counts");
    if (fail_count == 0 && pending == 0) begin
      $display("[hygienic_fork_mutex_node] OK");
    end else begin
      $display("[hygienic_fork_mutex_node] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
design/hfmn_pkg.sv
design/hfmn_front.sv
design/hfmn_cmd_fifo.sv
design/hfmn_back.sv
design/hygienic_fork_mutex_node.sv
design/hfmn_checker.sv
tb/hfmn_checker.sv
tb/hygienic_fork_mutex_node_tb.sv
